// ===== src/rbol_pkg.sv =====
// shared types and constants for the ring buffer offset lookup
`default_nettype none
package rbol_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int HANDLE_W  = 32;
    localparam int LEN_W     = 16;
    localparam int POS_W     = 20;
    localparam int SLOT_W    = 4;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_FIND = 1'b1
    } t_op;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] rem;
    } t_token;

endpackage
`default_nettype wire

// ===== src/rbol_cell.sv =====
// one ring slot: stored entry plus one step of the offset walk
`default_nettype none
module rbol_cell
    import rbol_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [LEN_W-1:0]    i_length,
    input  wire logic                i_rd_sel,
    input  wire logic                i_kill,
    input  wire t_token              i_tok,
    output t_token                   o_tok,
    output logic                     o_hit,
    output logic [LEN_W-1:0]         o_byte,
    output logic [HANDLE_W-1:0]      o_handle,
    output logic [LEN_W-1:0]         o_length
);

    logic [HANDLE_W-1:0] r_handle;
    logic [LEN_W-1:0]    r_length;
    t_token              r_tok;
    t_token              n_tok;
    logic [POS_W-1:0]    len_ext;
    logic                pick;

    assign len_ext = {{(POS_W-LEN_W){1'b0}}, r_length};
    assign o_hit   = i_tok.valid && (i_tok.rem < len_ext);
    assign pick    = o_hit || i_rd_sel;

    assign o_byte   = o_hit ? i_tok.rem[LEN_W-1:0] : '0;
    assign o_handle = pick ? r_handle : '0;
    assign o_length = pick ? r_length : '0;
    assign o_tok    = r_tok;

    always_comb begin
        n_tok.valid = i_tok.valid && !o_hit && !i_kill;
        n_tok.rem   = i_tok.rem - len_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handle  <= '0;
            r_length  <= '0;
            r_tok     <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr_en) begin
                r_handle <= i_handle;
                r_length <= i_length;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/ring_buffer_offset_lookup.sv =====
// top level: ring of slot cells with add and offset find
`default_nettype none
// Ring of SLOTS entries, each a 32-bit handle and a 16-bit byte length.
// Command channel: a beat is taken when start is high and busy is low.
// op add (0) writes the entry at the write index; if the ring was full the
// oldest entry is replaced and its handle comes back in o_evicted_handle.
// op find (1) looks up a character offset across all entries from the oldest.
// Result channel: one beat per command, shown for one cycle with o_strobe.
// The receiver cannot stall; results must be taken when strobed.
// An add gives its result in the cycle after acceptance and busy stays low,
// so adds may follow every cycle while no find is walking. A find passes a
// token from cell to cell, one slot per cycle, starting at the read index;
// the walk ends at the first slot that hits or after the last slot, and the
// result is registered from there; busy is high for the walk, so no new
// command is taken until a find has given its result.
// Reset clears all slots to length zero and handle zero, both indexes and the
// full flag; no clearing pass is needed.
module ring_buffer_offset_lookup
    import rbol_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_op,
    input  wire logic [HANDLE_W-1:0] i_new_handle,
    input  wire logic [LEN_W-1:0]    i_new_length,
    input  wire logic [POS_W-1:0]    i_char_position,
    output logic                     o_strobe,
    output logic                     o_found,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic [HANDLE_W-1:0]      o_hit_handle,
    output logic [LEN_W-1:0]         o_hit_length,
    output logic [LEN_W-1:0]         o_byte_within,
    output logic                     o_overwrote,
    output logic [HANDLE_W-1:0]      o_evicted_handle
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state              r_state;
    t_state              n_state;
    logic [IW-1:0]       r_wr_idx;
    logic [IW-1:0]       r_rd_idx;
    logic                r_full;
    logic [IW-1:0]       r_step;
    logic                r_inj_valid;
    logic [IW-1:0]       r_inj_slot;
    logic [POS_W-1:0]    r_inj_rem;

    logic [IW-1:0]       wr_next;
    logic [IW-1:0]       rd_next;
    logic                accept;
    logic                acc_add;
    logic                acc_find;
    logic                walking;
    logic                last_step;
    logic                kill;

    t_token              tok_in   [SLOTS];
    t_token              tok_out  [SLOTS];
    logic [SLOTS-1:0]    hit;
    logic [SLOTS-1:0]    wr_sel;
    logic [LEN_W-1:0]    c_byte   [SLOTS];
    logic [HANDLE_W-1:0] c_handle [SLOTS];
    logic [LEN_W-1:0]    c_length [SLOTS];

    logic                hit_any;
    logic [SLOT_W-1:0]   sel_slot;
    logic [HANDLE_W-1:0] sel_handle;
    logic [LEN_W-1:0]    sel_length;
    logic [LEN_W-1:0]    sel_byte;

    logic                r_strobe;
    logic                r_found;
    logic [SLOT_W-1:0]   r_slot;
    logic [HANDLE_W-1:0] r_hit_handle;
    logic [LEN_W-1:0]    r_hit_length;
    logic [LEN_W-1:0]    r_byte;
    logic                r_overwrote;
    logic [HANDLE_W-1:0] r_evicted;

    assign accept    = start && !busy;
    assign acc_add   = accept && (t_op'(i_op) == OP_ADD);
    assign acc_find  = accept && (t_op'(i_op) == OP_FIND);
    assign last_step = (r_step == LAST);
    assign wr_next   = (r_wr_idx == LAST) ? '0 : r_wr_idx + 1'b1;
    assign rd_next   = (r_rd_idx == LAST) ? '0 : r_rd_idx + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_find) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (hit_any || last_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy    = 1'b0;
        walking = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                walking = 1'b0;
            end
            ST_WALK: begin
                busy    = 1'b1;
                walking = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                walking = 1'b0;
            end
        endcase
    end

    assign kill = walking && last_step;

    // ring of cells, token handed on to the next slot
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic inj;
        assign inj       = r_inj_valid && (r_inj_slot == IW'(i));
        assign wr_sel[i] = acc_add && (r_wr_idx == IW'(i));
        assign tok_in[i].valid = inj || tok_out[(i + SLOTS - 1) % SLOTS].valid;
        assign tok_in[i].rem   = inj ? r_inj_rem : tok_out[(i + SLOTS - 1) % SLOTS].rem;

        rbol_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (wr_sel[i]),
            .i_handle (i_new_handle),
            .i_length (i_new_length),
            .i_rd_sel (wr_sel[i]),
            .i_kill   (kill),
            .i_tok    (tok_in[i]),
            .o_tok    (tok_out[i]),
            .o_hit    (hit[i]),
            .o_byte   (c_byte[i]),
            .o_handle (c_handle[i]),
            .o_length (c_length[i])
        );
    end

    // gathered hit and eviction data, at most one cell selected
    always_comb begin
        sel_slot   = '0;
        sel_handle = '0;
        sel_length = '0;
        sel_byte   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit[i]) begin
                sel_slot = sel_slot | SLOT_W'(i);
            end
            sel_handle = sel_handle | c_handle[i];
            sel_length = sel_length | c_length[i];
            sel_byte   = sel_byte | c_byte[i];
        end
    end

    assign hit_any = |hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_full      <= 1'b0;
            r_step      <= '0;
            r_inj_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inj_valid <= acc_find;
            r_strobe    <= 1'b0;
            if (acc_find) begin
                r_step <= '0;
            end else if (walking) begin
                r_step <= r_step + 1'b1;
            end
            if (acc_add) begin
                r_strobe <= 1'b1;
                r_wr_idx <= wr_next;
                if (r_full) begin
                    r_rd_idx <= rd_next;
                    r_full   <= (wr_next == rd_next);
                end else begin
                    r_full   <= (wr_next == r_rd_idx);
                end
            end
            if (walking && (hit_any || last_step)) begin
                r_strobe <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_find) begin
            r_inj_slot <= r_rd_idx;
            r_inj_rem  <= i_char_position;
        end
        if (acc_add) begin
            r_found      <= 1'b0;
            r_slot       <= '0;
            r_hit_handle <= '0;
            r_hit_length <= '0;
            r_byte       <= '0;
            r_overwrote  <= r_full;
            r_evicted    <= r_full ? sel_handle : '0;
        end else if (walking && (hit_any || last_step)) begin
            r_found      <= hit_any;
            r_slot       <= sel_slot;
            r_hit_handle <= sel_handle;
            r_hit_length <= sel_length;
            r_byte       <= sel_byte;
            r_overwrote  <= 1'b0;
            r_evicted    <= '0;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_found          = r_found;
    assign o_slot_index     = r_slot;
    assign o_hit_handle     = r_hit_handle;
    assign o_hit_length     = r_hit_length;
    assign o_byte_within    = r_byte;
    assign o_overwrote      = r_overwrote;
    assign o_evicted_handle = r_evicted;

endmodule
`default_nettype wire
